// File: hw/rtl/extent_map_translator_defines.svh
// assertion macros for the extent map translator
`ifndef EXTENT_MAP_TRANSLATOR_DEFINES_SVH
`define EXTENT_MAP_TRANSLATOR_DEFINES_SVH
// implication checked on every rising clock edge out of reset
`define EMT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define EMT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: hw/rtl/emt_pkg.sv
// shared types and constants of the extent map translator
package emt_pkg;
	localparam logic [2:0] ST_MAPPED   = 3'd0;
	localparam logic [2:0] ST_HOLE     = 3'd1;
	localparam logic [2:0] ST_PAST_END = 3'd2;
	localparam logic [2:0] ST_APPENDED = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;
	localparam logic [1:0] REG_BLOCK_LOG = 2'd0;
	localparam logic [1:0] REG_GROUP_LOG = 2'd1;
	localparam logic [1:0] REG_GROUP_BLK = 2'd2;
	localparam int SECTOR_LOG = 9;

	typedef struct packed {
		logic        lookup;
		logic        first;
		logic [53:0] off;
		logic [51:0] start;
		logic [20:0] len;
		logic [53:0] key;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_RD, BK_CMP, BK_MUL, BK_OUT
	} bk_state_t;
endpackage

// File: hw/rtl/emt_front.sv
// front: accepts items, unpacks records, queues commands
module emt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	output logic              stall,
	input  logic              op,
	input  logic              first_record,
	input  logic [31:0]       rec_word0,
	input  logic [31:0]       rec_word1,
	input  logic [31:0]       rec_word2,
	input  logic [31:0]       rec_word3,
	input  logic [53:0]       file_block,
	output logic              q_valid,
	output emt_pkg::cmd_t     q_cmd,
	input  logic              q_pop
);
	import emt_pkg::*;
	cmd_t     fifo_q [2];
	logic     wp_q, rp_q;
	logic [1:0] cnt_q;
	logic     push;
	cmd_t     c;

	assign stall = (cnt_q == 2'd2);
	assign push = valid && !stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = fifo_q[rp_q];

	always_comb begin
		c.lookup = op;
		c.first  = first_record;
		c.off    = {rec_word0[30:0], rec_word1[31:9]};
		c.start  = {rec_word1[8:0], rec_word2, rec_word3[31:21]};
		c.len    = rec_word3[20:0];
		c.key    = file_block;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

// File: hw/rtl/emt_back.sv
// back: extent table, scan and sector arithmetic
module emt_back #(
	parameter int MAX_EXTENTS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  emt_pkg::cmd_t     q_cmd,
	output logic              q_pop,
	input  logic [4:0]        block_log,
	input  logic [5:0]        group_block_log,
	input  logic [31:0]       group_blocks,
	output logic              valid,
	input  logic              stall,
	output logic [2:0]        status,
	output logic [59:0]       disk_sector,
	output logic [53:0]       run_blocks,
	output logic              busy
);
	import emt_pkg::*;
	localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
	localparam int CW = $clog2(MAX_EXTENTS + 1);

	logic [53:0] off_mem [MAX_EXTENTS];
	logic [51:0] start_mem [MAX_EXTENTS];
	logic [20:0] len_mem [MAX_EXTENTS];
	logic [53:0] off_rd_q;
	logic [51:0] start_rd_q;
	logic [20:0] len_rd_q;

	bk_state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	cmd_t cmd_q;
	logic [31:0] grp_q, blk_q;
	logic [63:0] lin_q;
	logic [2:0]  status_q;
	logic [53:0] run_q;
	logic [59:0] sec_q;
	logic        valid_q;

	logic [54:0] end_w;
	logic        hit, hole;
	logic [5:0]  gl;
	logic [52:0] fsb_w;
	logic [CW-1:0] base_cnt;
	logic        wr_en;
	logic [4:0]  sh;
	logic        take;
	logic [AW-1:0] rd_addr;

	assign take = q_valid && (state_q == BK_IDLE) && !(valid_q && stall);
	assign q_pop = take;
	assign busy = (state_q != BK_IDLE) || valid_q || q_valid;
	assign base_cnt = cmd_q.first ? '0 : count_q;
	assign wr_en = (state_q == BK_RD) && !cmd_q.lookup &&
		(base_cnt < CW'(MAX_EXTENTS));
	assign rd_addr = idx_q[AW-1:0];
	assign end_w = {1'b0, off_rd_q} + {34'd0, len_rd_q};
	assign hit = (cmd_q.key >= off_rd_q) && ({1'b0, cmd_q.key} < end_w);
	assign hole = cmd_q.key < off_rd_q;
	assign fsb_w = {1'b0, start_rd_q} + 53'(cmd_q.key - off_rd_q);
	assign gl = (group_block_log > 6'd32) ? 6'd32 : group_block_log;
	assign sh = (block_log < 5'd9) ? 5'd0 : block_log - 5'(SECTOR_LOG);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			off_mem[base_cnt[AW-1:0]]   <= cmd_q.off;
			start_mem[base_cnt[AW-1:0]] <= cmd_q.start;
			len_mem[base_cnt[AW-1:0]]   <= cmd_q.len;
		end
		off_rd_q   <= off_mem[rd_addr];
		start_rd_q <= start_mem[rd_addr];
		len_rd_q   <= len_mem[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (take) state_d = BK_RD;
			BK_RD: begin
				if (!cmd_q.lookup || idx_q >= count_q) begin
					state_d = BK_OUT;
				end else begin
					state_d = BK_CMP;
				end
			end
			BK_CMP: begin
				if (hit) begin
					state_d = BK_MUL;
				end else if (hole) begin
					state_d = BK_OUT;
				end else begin
					state_d = BK_RD;
				end
			end
			BK_MUL: state_d = BK_OUT;
			BK_OUT: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			count_q <= '0;
			idx_q <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (valid_q && !stall) begin
				valid_q <= 1'b0;
			end
			if (take) begin
				idx_q <= '0;
			end
			if (state_q == BK_RD && !cmd_q.lookup) begin
				count_q <= wr_en ? base_cnt + CW'(1) : base_cnt;
			end
			if (state_q == BK_CMP) begin
				idx_q <= idx_q + CW'(1);
			end
			if (state_q == BK_OUT) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= q_cmd;
		end
		case (state_q)
			BK_RD: begin
				status_q <= cmd_q.lookup ? ST_PAST_END : (wr_en ? ST_APPENDED : ST_FULL);
				run_q <= '0;
				sec_q <= '0;
			end
			BK_CMP: begin
				if (hit) begin
					status_q <= ST_MAPPED;
					run_q <= 54'(end_w - {1'b0, cmd_q.key});
					grp_q <= 32'(fsb_w >> gl);
					blk_q <= 32'(fsb_w & ((53'd1 << gl) - 53'd1));
				end else if (hole) begin
					status_q <= ST_HOLE;
					run_q <= off_rd_q - cmd_q.key;
				end
			end
			BK_MUL: lin_q <= {32'd0, grp_q} * {32'd0, group_blocks} + {32'd0, blk_q};
			BK_OUT: if (status_q == ST_MAPPED) sec_q <= 60'(lin_q << sh);
			default: ;
		endcase
	end

	assign valid = valid_q;
	assign status = status_q;
	assign disk_sector = sec_q;
	assign run_blocks = run_q;
endmodule

// File: hw/rtl/extent_map_translator.sv
// top level of the extent map translator
// Append items store one extent, unless the table is full, and return a result.
// Lookups scan the stored extents one per memory read, each extent taking a
// read state and a compare state, and stop at a hit, a hole or the end.
// A two-entry command queue lets items be taken while the scan runs.
module extent_map_translator #(
	parameter int MAX_EXTENTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic        first_record,
	input  logic [31:0] rec_word0,
	input  logic [31:0] rec_word1,
	input  logic [31:0] rec_word2,
	input  logic [31:0] rec_word3,
	input  logic [53:0] file_block,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [59:0] disk_sector,
	output logic [53:0] run_blocks,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import emt_pkg::*;
	`include "extent_map_translator_defines.svh"

	logic q_valid, q_pop, busy;
	cmd_t q_cmd;
	logic [4:0]  block_log_q;
	logic [5:0]  group_log_q;
	logic [31:0] group_blocks_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_log_q <= 5'd12;
			group_log_q <= 6'd16;
			group_blocks_q <= 32'd65536;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BLOCK_LOG: block_log_q <= cfg_data[4:0];
				REG_GROUP_LOG: group_log_q <= cfg_data[5:0];
				REG_GROUP_BLK: group_blocks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	emt_front u_front (
		.clk, .arst_n,
		.valid(in_valid), .stall(in_stall),
		.op, .first_record, .rec_word0, .rec_word1, .rec_word2, .rec_word3,
		.file_block,
		.q_valid, .q_cmd, .q_pop
	);

	emt_back #(.MAX_EXTENTS(MAX_EXTENTS)) u_back (
		.clk, .arst_n,
		.q_valid, .q_cmd, .q_pop,
		.block_log(block_log_q), .group_block_log(group_log_q),
		.group_blocks(group_blocks_q),
		.valid(out_valid), .stall(out_stall),
		.status, .disk_sector, .run_blocks, .busy
	);

	`EMT_ASSERT_IMP(a_pop_has_item, q_pop, q_valid)
	`EMT_ASSERT_IMP(a_status_known, out_valid, status <= ST_FULL)
	`EMT_ASSERT_IMP(a_sector_zero, out_valid && status != ST_MAPPED, disk_sector == 60'd0)
	`EMT_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid && $stable(status))
	`EMT_ASSERT_IMP(a_cfg_idle, cfg_valid && cfg_ready, !busy)
endmodule

// File: dv/tb_extent_map_translator.sv
// self-checking testbench of the extent map translator: directed and random items
module tb_extent_map_translator;
	timeunit 1ns;
	timeprecision 1ps;
	import emt_pkg::*;

	localparam int DEPTH = 64;
	localparam int SCAN_CYCLES = 2 * DEPTH + 12;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic [2:0]  status;
		logic [59:0] sector;
		logic [53:0] run;
	} xlat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = 1'b0;
	logic        first_record = 1'b0;
	logic [31:0] rec_word0 = '0;
	logic [31:0] rec_word1 = '0;
	logic [31:0] rec_word2 = '0;
	logic [31:0] rec_word3 = '0;
	logic [53:0] file_block = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [59:0] disk_sector;
	logic [53:0] run_blocks;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// predictor state
	logic [53:0] ext_off [DEPTH];
	logic [51:0] ext_start [DEPTH];
	logic [20:0] ext_len [DEPTH];
	int          ext_n = 0;
	logic [4:0]  blk_log = 5'd12;
	logic [5:0]  grp_log = 6'd16;
	logic [31:0] grp_blocks = 32'd65536;

	xlat_t pending_xlat[$];
	int    fails = 0;
	int    sent = 0;
	int    idle_cycles = 0;
	bit    quiet = 0;
	bit    hold_req = 0;
	bit    held = 0;
	int    hold_cnt = 0;

	extent_map_translator #(.MAX_EXTENTS(DEPTH)) u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [59:0] sector_of(logic [63:0] fsb);
		int unsigned gl;
		int unsigned sh;
		logic [63:0] grp;
		logic [63:0] lin;
		gl = grp_log > 32 ? 32 : grp_log;
		sh = blk_log < SECTOR_LOG ? 0 : blk_log - SECTOR_LOG;
		grp = (fsb >> gl) & 64'hFFFF_FFFF;
		lin = grp * {32'd0, grp_blocks} + (fsb & ((64'd1 << gl) - 64'd1));
		lin = lin << sh;
		return lin[59:0];
	endfunction

	function automatic xlat_t translate(logic lk, logic fr, logic [31:0] w0, logic [31:0] w1,
			logic [31:0] w2, logic [31:0] w3, logic [53:0] key);
		xlat_t r;
		logic [63:0] lo;
		logic [63:0] hi;
		r = '{status: ST_PAST_END, sector: '0, run: '0};
		if (!lk) begin
			if (fr) ext_n = 0;
			if (ext_n >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				ext_off[ext_n] = {w0[30:0], w1[31:9]};
				ext_start[ext_n] = {w1[8:0], w2, w3[31:21]};
				ext_len[ext_n] = w3[20:0];
				ext_n++;
				r.status = ST_APPENDED;
			end
			return r;
		end
		for (int i = 0; i < ext_n; i++) begin
			lo = {10'd0, ext_off[i]};
			hi = lo + {43'd0, ext_len[i]};
			if (key >= lo && key < hi) begin
				r.status = ST_MAPPED;
				r.sector = sector_of({12'd0, ext_start[i]} + ({10'd0, key} - lo));
				r.run = 54'(hi - key);
				return r;
			end
			if (key < lo) begin
				r.status = ST_HOLE;
				r.run = 54'(lo - key);
				return r;
			end
		end
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		xlat_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_xlat.size() == 0) begin
				$error("result beat with nothing expected");
				fails++;
			end else begin
				e = pending_xlat.pop_front();
				if (status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, status);
					fails++;
				end
				if (disk_sector !== e.sector) begin
					$error("disk_sector expected %0h actual %0h", e.sector, disk_sector);
					fails++;
				end
				if (run_blocks !== e.run) begin
					$error("run_blocks expected %0h actual %0h", e.run, run_blocks);
					fails++;
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (!hold_req) held = 0;
		if (hold_req && !held) begin
			held = 1;
			hold_cnt = LONG_HOLD;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else if (out_stall) begin
			out_stall <= $urandom_range(0, 2) != 0 ? 1'b0 : 1'b1;
		end else begin
			out_stall <= $urandom_range(0, 7) == 0;
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// called and returns at a falling edge
	task automatic send_item(logic lk, logic fr, logic [31:0] w0, logic [31:0] w1,
			logic [31:0] w2, logic [31:0] w3, logic [53:0] key);
		int gap;
		op <= lk;
		first_record <= fr;
		rec_word0 <= w0;
		rec_word1 <= w1;
		rec_word2 <= w2;
		rec_word3 <= w3;
		file_block <= key;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_xlat.push_back(translate(lk, fr, w0, w1, w2, w3, key));
		sent++;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic append_extent(logic fr, logic [53:0] off, logic [51:0] start,
			logic [20:0] len);
		send_item(1'b0, fr, {1'($urandom), off[53:23]}, {off[22:0], start[51:43]},
			start[42:11], {start[10:0], len}, 54'({$urandom, $urandom}));
	endtask

	task automatic lookup(logic [53:0] key);
		send_item(1'b1, 1'($urandom), $urandom, $urandom, $urandom, $urandom, key);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (pending_xlat.size() == 0);
		repeat (SCAN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		in_valid <= 1'b0;
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_BLOCK_LOG: blk_log = data[4:0];
			REG_GROUP_LOG: grp_log = data[5:0];
			REG_GROUP_BLK: grp_blocks = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_geometry(logic [4:0] bl, logic [5:0] gl, logic [31:0] gb);
		drain();
		write_reg(REG_BLOCK_LOG, {27'd0, bl});
		write_reg(REG_GROUP_LOG, {26'd0, gl});
		write_reg(REG_GROUP_BLK, gb);
	endtask

	function automatic logic [53:0] key_near_table();
		int i;
		logic [63:0] k;
		if (ext_n == 0 || $urandom_range(0, 9) == 0)
			return 54'({$urandom, $urandom});
		i = $urandom_range(0, ext_n - 1);
		k = {10'd0, ext_off[i]} + $urandom_range(0, ext_len[i] + 2) - 2;
		return k[53:0];
	endfunction

	task automatic test_directed();
		lookup('0);
		append_extent(1'b1, 54'd100, 52'd5000, 21'd10);
		lookup(54'd100);
		lookup(54'd109);
		lookup(54'd110);
		lookup(54'd50);
		append_extent(1'b0, 54'd200, 52'hF_FFFF_FFFF_FFFF, 21'h1F_FFFF);
		lookup(54'd150);
		lookup(54'd200);
		lookup(54'd250);
		append_extent(1'b0, 54'd5000000, 52'd1, 21'd0);
		lookup(54'd5000000);
		lookup(54'd4000000);
		append_extent(1'b0, 54'd0, 52'd77, 21'd1000);
		lookup(54'd20);
		lookup('1);
		append_extent(1'b1, '1, '1, '1);
		lookup('1);
		lookup(54'h3F_FFFF_FFFF_FFFE);
		send_item(1'b0, 1'b0, '1, '1, '1, '1, '1);
		send_item(1'b0, 1'b1, '0, '0, '0, '0, '0);
		lookup('0);
	endtask

	task automatic test_full_table();
		append_extent(1'b1, 54'd0, 52'd900, 21'd4);
		for (int i = 1; i < DEPTH; i++)
			append_extent(1'b0, 54'(i * 8), 52'(i * 1000), 21'd4);
		append_extent(1'b0, 54'd9999, 52'd1, 21'd1);
		lookup(54'(DEPTH * 8 - 6));
		lookup(54'(DEPTH * 8 + 5));
		lookup(54'd13);
		append_extent(1'b1, 54'd40, 52'd3, 21'd2);
		lookup(54'd41);
	endtask

	task automatic test_geometry();
		logic [4:0]  bls [5] = '{5'd9, 5'd16, 5'd12, 5'd0, 5'd31};
		logic [5:0]  gls [5] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd20};
		logic [31:0] gbs [5] = '{32'd1, 32'hFFFF_FFFF, 32'd1000, 32'd0, 32'h8000_0001};
		for (int s = 0; s < 5; s++) begin
			set_geometry(bls[s], gls[s], gbs[s]);
			append_extent(1'b1, 54'd10, {20'hABCDE, $urandom}, 21'h1F_FFFF);
			append_extent(1'b0, 54'd3_000_000, '1, 21'd5);
			for (int i = 0; i < 4; i++) lookup(key_near_table());
		end
		set_geometry(5'd12, 6'd16, 32'd65536);
	endtask

	task automatic test_backpressure();
		hold_req = 1;
		append_extent(1'b1, 54'd1000, 52'd1, 21'd100);
		for (int i = 0; i < 30; i++) lookup(key_near_table());
		hold_req = 0;
		drain();
	endtask

	task automatic random_table(int target);
		int n;
		logic [63:0] base;
		while (sent < target) begin
			if ($urandom_range(0, 11) == 0) begin
				set_geometry(5'($urandom_range(9, 16)), 6'($urandom_range(1, 32)), $urandom);
			end
			n = $urandom_range(0, 19) == 0 ? $urandom_range(20, DEPTH + 3) : $urandom_range(1, 8);
			base = $urandom_range(0, 3) == 0 ? {10'd0, $urandom, 22'($urandom)}
				: 64'($urandom_range(0, 5000));
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 15) == 0) begin
					send_item(1'b0, 1'b0, $urandom, $urandom, $urandom, $urandom, '0);
				end else begin
					append_extent(i == 0, base[53:0], {20'($urandom), $urandom},
						$urandom_range(0, 3) == 0 ? 21'($urandom) : 21'($urandom_range(0, 64)));
					base = base + ext_len[ext_n > 0 ? ext_n - 1 : 0]
						+ ($urandom_range(0, 1) ? 0 : $urandom_range(1, 50));
				end
			end
			repeat ($urandom_range(2, 12)) lookup(key_near_table());
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_full_table();
		test_geometry();
		test_backpressure();
		random_table(1250);
		drain();
		quiet = 1;
		random_table(1450);
		drain();
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
